// File: sv/sfau_pkg.sv
// Shared types, codes and constants for the single-precision arithmetic unit.
package sfau_pkg;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  localparam logic [31:0] QUIET_BIT = 32'h0040_0000;
  localparam logic [31:0] QNAN      = 32'h7FC0_0000;
  localparam logic [7:0]  EXP_MAX   = 8'd255;
  localparam logic signed [9:0] BIAS = 10'sd127;

  localparam int DIV_STEPS = 5;

  typedef struct packed {
    logic [1:0]        kind;
    logic              spec;
    logic [31:0]       spec_val;
    logic              rs;
    logic              sb;
    logic signed [9:0] re;
    logic [24:0]       ma;
    logic [23:0]       mb;
    logic [7:0]        sh;
    logic [24:0]       q;
    logic [47:0]       prod;
  } pl_t;

endpackage

// File: sv/sfau_div_stage.sv
// Five restoring-division steps of the mantissa quotient.
module sfau_div_stage (
  input  logic [24:0] rem_i,
  input  logic [24:0] quo_i,
  input  logic [23:0] div_i,
  output logic [24:0] rem_o,
  output logic [24:0] quo_o
);
  import sfau_pkg::*;

  always_comb begin
    logic [24:0] r;
    logic [24:0] q;
    r = rem_i;
    q = quo_i;
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (r >= {1'b0, div_i}) begin
        r = r - {1'b0, div_i};
        q = {q[23:0], 1'b1};
      end else begin
        q = {q[23:0], 1'b0};
      end
      r = {r[23:0], 1'b0};
    end
    rem_o = r;
    quo_o = q;
  end

endmodule

// File: sv/single_float_arith_unit.sv
// Top level: pipelined single-precision add, subtract, multiply and divide.
// Throughput: one word per cycle while the output is not stalled;
// the divider retires five quotient bits per stage.
// A stalled output word holds the whole pipeline in place.
// Reset (rst_n low, synchronous) clears all stage valid bits; data registers keep.
module single_float_arith_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_bits
);
  import sfau_pkg::*;

  logic advance;
  logic [7:1] v_r;
  pl_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r;
  pl_t s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt, s6_nxt, s7_nxt;
  logic [24:0] rem_o [2:6];
  logic [24:0] quo_o [2:6];

  assign advance  = !(v_r[7] && out_stall);
  assign in_stall = !advance;
  assign out_valid = v_r[7];
  assign out_result_bits = s7_r.spec_val;

  // decode, specials, operand swap
  always_comb begin
    logic [31:0] a, b;
    logic [7:0] ea, eb;
    logic [22:0] fa, fb;
    logic za, zb, na, nb, sgn;
    a = in_operand_a;
    b = (in_kind == KIND_SUB) ? (in_operand_b ^ 32'h8000_0000) : in_operand_b;
    ea = a[30:23];
    eb = b[30:23];
    fa = a[22:0];
    fb = b[22:0];
    za = (ea == 8'd0) && (fa == 23'd0);
    zb = (eb == 8'd0) && (fb == 23'd0);
    na = (ea == EXP_MAX) && (fa != 23'd0);
    nb = (eb == EXP_MAX) && (fb != 23'd0);
    sgn = a[31] ^ b[31];
    s1_nxt = '0;
    s1_nxt.kind = in_kind;
    if (in_kind == KIND_ADD || in_kind == KIND_SUB) begin
      if (ea == EXP_MAX) begin
        s1_nxt.spec = 1'b1;
        s1_nxt.spec_val = (fa != 23'd0) ? (a | QUIET_BIT) : a;
      end else if (eb == EXP_MAX) begin
        s1_nxt.spec = 1'b1;
        s1_nxt.spec_val = (fb != 23'd0) ? (b | QUIET_BIT) : b;
      end else if (za) begin
        s1_nxt.spec = 1'b1;
        s1_nxt.spec_val = b;
      end else if (zb) begin
        s1_nxt.spec = 1'b1;
        s1_nxt.spec_val = a;
      end
      if (ea < eb) begin
        s1_nxt.rs = b[31];
        s1_nxt.sb = a[31];
        s1_nxt.re = {2'b00, eb};
        s1_nxt.sh = eb - ea;
        s1_nxt.ma = {1'b0, (eb != 8'd0), fb};
        s1_nxt.mb = {(ea != 8'd0), fa};
      end else begin
        s1_nxt.rs = a[31];
        s1_nxt.sb = b[31];
        s1_nxt.re = {2'b00, ea};
        s1_nxt.sh = ea - eb;
        s1_nxt.ma = {1'b0, (ea != 8'd0), fa};
        s1_nxt.mb = {(eb != 8'd0), fb};
      end
    end else if (in_kind == KIND_MUL) begin
      s1_nxt.rs = sgn;
      s1_nxt.re = $signed({2'b00, ea}) + $signed({2'b00, eb}) - BIAS;
      s1_nxt.ma = {2'b01, fa};
      s1_nxt.mb = {1'b1, fb};
      if (ea == EXP_MAX || eb == EXP_MAX) begin
        s1_nxt.spec = 1'b1;
        s1_nxt.spec_val = (na || nb || za || zb) ? QNAN : {sgn, EXP_MAX, 23'd0};
      end else if (za || zb) begin
        s1_nxt.spec = 1'b1;
        s1_nxt.spec_val = {sgn, 31'd0};
      end
    end else begin
      s1_nxt.rs = sgn;
      s1_nxt.re = $signed({2'b00, ea}) - $signed({2'b00, eb}) + BIAS;
      s1_nxt.ma = {2'b01, fa};
      s1_nxt.mb = {1'b1, fb};
      s1_nxt.spec = 1'b1;
      if (na || nb) begin
        s1_nxt.spec_val = QNAN;
      end else if (ea == EXP_MAX) begin
        s1_nxt.spec_val = {sgn, EXP_MAX, 23'd0};
      end else if (eb == EXP_MAX) begin
        s1_nxt.spec_val = {sgn, 31'd0};
      end else if (za) begin
        s1_nxt.spec_val = zb ? QNAN : {sgn, 31'd0};
      end else if (zb) begin
        s1_nxt.spec_val = {sgn, EXP_MAX, 23'd0};
      end else begin
        s1_nxt.spec = 1'b0;
      end
    end
  end

  sfau_div_stage u_div2 (.rem_i(s1_r.ma), .quo_i(s1_r.q), .div_i(s1_r.mb),
                         .rem_o(rem_o[2]), .quo_o(quo_o[2]));
  sfau_div_stage u_div3 (.rem_i(s2_r.ma), .quo_i(s2_r.q), .div_i(s2_r.mb),
                         .rem_o(rem_o[3]), .quo_o(quo_o[3]));
  sfau_div_stage u_div4 (.rem_i(s3_r.ma), .quo_i(s3_r.q), .div_i(s3_r.mb),
                         .rem_o(rem_o[4]), .quo_o(quo_o[4]));
  sfau_div_stage u_div5 (.rem_i(s4_r.ma), .quo_i(s4_r.q), .div_i(s4_r.mb),
                         .rem_o(rem_o[5]), .quo_o(quo_o[5]));
  sfau_div_stage u_div6 (.rem_i(s5_r.ma), .quo_i(s5_r.q), .div_i(s5_r.mb),
                         .rem_o(rem_o[6]), .quo_o(quo_o[6]));

  // align smaller addend, multiply, division steps
  always_comb begin
    s2_nxt = s1_r;
    if (s1_r.kind == KIND_ADD || s1_r.kind == KIND_SUB) begin
      s2_nxt.mb = (s1_r.sh >= 8'd25) ? 24'd0 : (s1_r.mb >> s1_r.sh);
    end else if (s1_r.kind == KIND_MUL) begin
      s2_nxt.prod = s1_r.ma[23:0] * s1_r.mb;
    end else begin
      s2_nxt.ma = rem_o[2];
      s2_nxt.q  = quo_o[2];
    end
  end

  // add or subtract magnitudes, normalize product, division steps
  always_comb begin
    logic [24:0] sum;
    sum = s2_r.ma + {1'b0, s2_r.mb};
    s3_nxt = s2_r;
    if (s2_r.kind == KIND_ADD || s2_r.kind == KIND_SUB) begin
      if (s2_r.rs == s2_r.sb) begin
        if (sum[24]) begin
          s3_nxt.ma = {1'b0, sum[24:1]};
          s3_nxt.re = s2_r.re + 10'sd1;
        end else begin
          s3_nxt.ma = sum;
        end
      end else begin
        if (s2_r.ma[23:0] >= s2_r.mb) begin
          s3_nxt.ma = {1'b0, s2_r.ma[23:0] - s2_r.mb};
        end else begin
          s3_nxt.ma = {1'b0, s2_r.mb - s2_r.ma[23:0]};
          s3_nxt.rs = s2_r.sb;
        end
        if (s2_r.ma[23:0] == s2_r.mb && !s2_r.spec) begin
          s3_nxt.spec = 1'b1;
          s3_nxt.spec_val = 32'd0;
        end
      end
    end else if (s2_r.kind == KIND_MUL) begin
      if (s2_r.prod[47]) begin
        s3_nxt.ma = {1'b0, s2_r.prod[47:24]};
        s3_nxt.re = s2_r.re + 10'sd1;
      end else begin
        s3_nxt.ma = {1'b0, s2_r.prod[46:23]};
      end
    end else begin
      s3_nxt.ma = rem_o[3];
      s3_nxt.q  = quo_o[3];
    end
  end

  // leading-zero count, limited by exponent; division steps
  always_comb begin
    logic [7:0] lz;
    logic signed [9:0] lim;
    lz = 8'd24;
    for (int i = 0; i < 24; i++) begin
      if (s3_r.ma[i]) lz = 8'(23 - i);
    end
    lim = s3_r.re - 10'sd1;
    s4_nxt = s3_r;
    if (s3_r.kind == KIND_ADD || s3_r.kind == KIND_SUB) begin
      if (s3_r.re <= 10'sd1) begin
        s4_nxt.sh = 8'd0;
      end else if ($signed({2'b00, lz}) < lim) begin
        s4_nxt.sh = lz;
      end else begin
        s4_nxt.sh = lim[7:0];
      end
    end else if (s3_r.kind == KIND_DIV) begin
      s4_nxt.ma = rem_o[4];
      s4_nxt.q  = quo_o[4];
    end
  end

  // normalizing shift, division steps
  always_comb begin
    s5_nxt = s4_r;
    if (s4_r.kind == KIND_ADD || s4_r.kind == KIND_SUB) begin
      s5_nxt.ma = {1'b0, s4_r.ma[23:0] << s4_r.sh};
      s5_nxt.re = s4_r.re - $signed({2'b00, s4_r.sh});
    end else if (s4_r.kind == KIND_DIV) begin
      s5_nxt.ma = rem_o[5];
      s5_nxt.q  = quo_o[5];
    end
  end

  always_comb begin
    s6_nxt = s5_r;
    if (s5_r.kind == KIND_DIV) begin
      s6_nxt.ma = rem_o[6];
      s6_nxt.q  = quo_o[6];
    end
  end

  // pack result
  always_comb begin
    logic [23:0] rm;
    logic signed [9:0] re;
    rm = s6_r.ma[23:0];
    re = s6_r.re;
    if (s6_r.kind == KIND_DIV) begin
      if (s6_r.q[24]) begin
        rm = s6_r.q[24:1];
      end else begin
        rm = s6_r.q[23:0];
        re = s6_r.re - 10'sd1;
      end
    end
    s7_nxt = s6_r;
    if (!s6_r.spec) begin
      if (re >= $signed({2'b00, EXP_MAX})) begin
        s7_nxt.spec_val = {s6_r.rs, EXP_MAX, 23'd0};
      end else if (re <= 10'sd0) begin
        s7_nxt.spec_val = {s6_r.rs, 31'd0};
      end else begin
        s7_nxt.spec_val = {s6_r.rs, re[7:0], rm[22:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (advance) begin
      v_r <= {v_r[6:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
      s7_r <= s7_nxt;
    end
  end

`ifndef SYNTH
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> v_r[1] == $past(in_valid))
    else $error("input word not captured into first stage");
  a_exit: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid == $past(v_r[6]))
    else $error("word lost or invented at output stage");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(v_r))
    else $error("pipeline moved during stall");
  a_quo: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[6] && s6_r.kind == KIND_DIV && !s6_r.spec) |-> (s6_r.q[24] || s6_r.q[23]))
    else $error("quotient not normalized");
`endif

endmodule
